@@ hdl/gkg_pkg.sv @@
package gkg_pkg;

    // sizes of the point store and the fields
    localparam int MAX_POINTS = 1024;
    localparam int PTR_W      = 10;
    localparam int CNT_W      = 11;
    localparam int COORD_W    = 16;
    localparam int VALUE_W    = 24;
    localparam int GRID_W     = 4;
    localparam int IDX_W      = 3;
    localparam int MAX_GRID   = 8;
    localparam int CFG_IDX_W  = 2;

    // kernel arithmetic widths
    localparam int CENTER_W   = 24;
    localparam int ABS_W      = 23;
    localparam int SQ_W       = 46;
    localparam int D2_W       = 47;
    localparam int NUM_W      = 48;
    localparam int H2_W       = 32;
    localparam int REM_W      = 40;
    localparam int EXP_DEPTH  = 256;
    localparam int EXP_ADDR_W = 8;
    localparam int WGT_W      = 16;
    localparam int PROD_W     = 41;
    localparam int WT_W       = 27;
    localparam int WVT_W      = 50;

    // shared divider widths
    localparam int DIV_N_W    = 50;
    localparam int DIV_D_W    = 27;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;

    // taylor terms of exp(-16/depth) in q30, each the previous times 16/(depth*n)
    localparam longint EXP_ONE = longint'(1) <<< 30;
    localparam longint EXP_T1  = EXP_ONE * 16 / (longint'(EXP_DEPTH) * 1);
    localparam longint EXP_T2  = EXP_T1 * 16 / (longint'(EXP_DEPTH) * 2);
    localparam longint EXP_T3  = EXP_T2 * 16 / (longint'(EXP_DEPTH) * 3);
    localparam longint EXP_T4  = EXP_T3 * 16 / (longint'(EXP_DEPTH) * 4);
    localparam longint EXP_T5  = EXP_T4 * 16 / (longint'(EXP_DEPTH) * 5);
    localparam longint EXP_T6  = EXP_T5 * 16 / (longint'(EXP_DEPTH) * 6);
    localparam longint EXP_T7  = EXP_T6 * 16 / (longint'(EXP_DEPTH) * 7);
    localparam longint EXP_T8  = EXP_T7 * 16 / (longint'(EXP_DEPTH) * 8);
    localparam longint EXP_T9  = EXP_T8 * 16 / (longint'(EXP_DEPTH) * 9);
    localparam longint EXP_T10 = EXP_T9 * 16 / (longint'(EXP_DEPTH) * 10);
    localparam longint EXP_T11 = EXP_T10 * 16 / (longint'(EXP_DEPTH) * 11);
    localparam longint EXP_T12 = EXP_T11 * 16 / (longint'(EXP_DEPTH) * 12);
    localparam longint EXP_RATIO = EXP_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4 - EXP_T5
                                   + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9 + EXP_T10
                                   - EXP_T11 + EXP_T12;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PITCH_GO,
        ST_PITCH_WAIT,
        ST_H2_MUL,
        ST_H2_GO,
        ST_H2_WAIT,
        ST_CELL_SETUP,
        ST_CELL_ISSUE,
        ST_CELL_DRAIN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic pitch_go;
        logic pitch_latch;
        logic h2_mul;
        logic h2_go;
        logic h2_latch;
        logic cell_setup;
        logic issue;
        logic cell_go;
        logic out_load;
        logic cell_next;
        logic set_clear;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic issue_last;
        logic pipe_empty;
        logic grid_last;
    } t_sts;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [VALUE_W-1:0] val;
    } t_point;

    typedef logic [WGT_W-1:0] t_exp_rom [0:EXP_DEPTH-1];

    // exp(-16k/depth) in Q0.16, built from a Q30 ratio by repeated products
    function automatic t_exp_rom build_exp_rom();
        t_exp_rom rom;
        longint   v;
        longint   w;
        v = EXP_ONE;
        for (int k = 0; k < EXP_DEPTH; k++) begin
            if (k > 0) begin
                v = (v * EXP_RATIO + (longint'(1) <<< 29)) >>> 30;
            end
            w = (v + (longint'(1) <<< 13)) >>> 14;
            rom[k] = (w > 65535) ? 16'hFFFF : w[15:0];
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = build_exp_rom();

endpackage

@@ hdl/gkg_div.sv @@
module gkg_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [gkg_pkg::DIV_N_W-1:0]         i_dividend,
    input  logic [gkg_pkg::DIV_D_W-1:0]         i_divisor,
    output logic                                o_done,
    output logic [gkg_pkg::DIV_N_W-1:0]         o_quotient
);

    localparam int N_W   = gkg_pkg::DIV_N_W;
    localparam int D_W   = gkg_pkg::DIV_D_W;
    localparam int STEP_W = $clog2(N_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [D_W-1:0]    r_rem;
    logic [N_W-1:0]    r_quo;
    logic [D_W-1:0]    r_div;

    logic [D_W:0]      w_trial;
    logic [D_W:0]      w_diff;
    logic              w_ge;

    // one restoring step: shift in next dividend bit, try subtract
    assign w_trial = {r_rem, r_quo[N_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(N_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
            r_quo <= {r_quo[N_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ hdl/gkg_dpath.sv @@
module gkg_dpath (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [gkg_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [gkg_pkg::GRID_W-1:0]              i_cfg_data,
    input  logic signed [gkg_pkg::COORD_W-1:0]      i_x_coord,
    input  logic signed [gkg_pkg::COORD_W-1:0]      i_y_coord,
    input  logic signed [gkg_pkg::VALUE_W-1:0]      i_sample_value,
    input  gkg_pkg::t_cmd                           i_cmd,
    output gkg_pkg::t_sts                           o_sts,
    output logic signed [gkg_pkg::VALUE_W-1:0]      o_cell_value,
    output logic [gkg_pkg::IDX_W-1:0]               o_column_index,
    output logic [gkg_pkg::IDX_W-1:0]               o_row_index,
    output logic                                    o_no_weight,
    output logic                                    o_points_dropped,
    output logic                                    o_last_cell
);

    localparam int COORD_W  = gkg_pkg::COORD_W;
    localparam int VALUE_W  = gkg_pkg::VALUE_W;
    localparam int GRID_W   = gkg_pkg::GRID_W;
    localparam int IDX_W    = gkg_pkg::IDX_W;
    localparam int PTR_W    = gkg_pkg::PTR_W;
    localparam int CNT_W    = gkg_pkg::CNT_W;
    localparam int CENTER_W = gkg_pkg::CENTER_W;
    localparam int ABS_W    = gkg_pkg::ABS_W;
    localparam int SQ_W     = gkg_pkg::SQ_W;
    localparam int D2_W     = gkg_pkg::D2_W;
    localparam int NUM_W    = gkg_pkg::NUM_W;
    localparam int H2_W     = gkg_pkg::H2_W;
    localparam int REM_W    = gkg_pkg::REM_W;
    localparam int QB       = gkg_pkg::EXP_ADDR_W;
    localparam int WGT_W    = gkg_pkg::WGT_W;
    localparam int PROD_W   = gkg_pkg::PROD_W;
    localparam int WT_W     = gkg_pkg::WT_W;
    localparam int WVT_W    = gkg_pkg::WVT_W;
    localparam int DIV_N_W  = gkg_pkg::DIV_N_W;
    localparam int DIV_D_W  = gkg_pkg::DIV_D_W;
    localparam int OFF_W    = 2 * COORD_W - 12;

    // configuration
    logic [GRID_W-1:0] r_cols;
    logic [GRID_W-1:0] r_rows;
    logic [GRID_W-1:0] w_cols;
    logic [GRID_W-1:0] w_rows;

    // point set state
    logic [CNT_W-1:0]          r_count;
    logic                      r_ovf;
    logic signed [COORD_W-1:0] r_min_x;
    logic signed [COORD_W-1:0] r_max_x;
    logic signed [COORD_W-1:0] r_min_y;
    logic signed [COORD_W-1:0] r_max_y;
    gkg_pkg::t_point           mem [0:gkg_pkg::MAX_POINTS-1];

    // grid setup
    logic [COORD_W-1:0]        w_xspan;
    logic [COORD_W-1:0]        w_yspan;
    logic [COORD_W:0]          w_xspan_full;
    logic [COORD_W:0]          w_yspan_full;
    logic [COORD_W-1:0]        r_pitch;
    logic [H2_W-1:0]           r_h2_prod;
    logic [H2_W-1:0]           r_h2;

    // cell position and centre
    logic [IDX_W-1:0]          r_ci;
    logic [IDX_W-1:0]          r_cj;
    logic [OFF_W-1:0]          w_off_x;
    logic [OFF_W-1:0]          w_off_y;
    logic signed [CENTER_W-1:0] r_cx2;
    logic signed [CENTER_W-1:0] r_cy2;
    logic                      w_col_end;
    logic                      w_row_end;

    // point pipeline
    logic [PTR_W-1:0]          r_k;
    gkg_pkg::t_point           r_rd;
    logic                      r_v0;
    logic signed [CENTER_W-1:0] w_dx;
    logic signed [CENTER_W-1:0] w_dy;
    logic [ABS_W-1:0]          r_adx;
    logic [ABS_W-1:0]          r_ady;
    logic signed [VALUE_W-1:0] r_val1;
    logic                      r_v1;
    logic [SQ_W-1:0]           r_sqx;
    logic [SQ_W-1:0]           r_sqy;
    logic signed [VALUE_W-1:0] r_val2;
    logic                      r_v2;
    logic [D2_W-1:0]           w_d2;
    logic [NUM_W-1:0]          w_num;
    logic                      w_far;
    logic [REM_W-1:0]          r_drem [0:QB];
    logic [QB-1:0]             r_dq   [0:QB];
    logic signed [VALUE_W-1:0] r_dval [0:QB];
    logic                      r_dfar [0:QB];
    logic                      r_dv   [0:QB];
    logic [WGT_W-1:0]          w_w;
    logic [WGT_W-1:0]          r_w;
    logic signed [PROD_W-1:0]  r_wv;
    logic                      r_ve;
    logic [WT_W-1:0]           r_wt;
    logic signed [WVT_W-1:0]   r_wvt;
    logic                      w_div_busy_any;

    // divider
    logic                      w_div_start;
    logic [DIV_N_W-1:0]        w_dividend;
    logic [DIV_D_W-1:0]        w_divisor;
    logic                      w_div_done;
    logic [DIV_N_W-1:0]        w_quotient;
    logic                      w_neg;
    logic [WVT_W-1:0]          w_mag;
    logic                      w_wt_zero;
    logic [VALUE_W-1:0]        w_q_lo;

    // register writes, clamped on use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= GRID_W'(gkg_pkg::MAX_GRID);
            r_rows <= GRID_W'(gkg_pkg::MAX_GRID);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gkg_pkg::CFG_COLUMNS: r_cols <= i_cfg_data;
                gkg_pkg::CFG_ROWS:    r_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_cols = r_cols;
        if (r_cols == '0) begin
            w_cols = GRID_W'(1);
        end else if (r_cols > GRID_W'(gkg_pkg::MAX_GRID)) begin
            w_cols = GRID_W'(gkg_pkg::MAX_GRID);
        end
        w_rows = r_rows;
        if (r_rows == '0) begin
            w_rows = GRID_W'(1);
        end else if (r_rows > GRID_W'(gkg_pkg::MAX_GRID)) begin
            w_rows = GRID_W'(gkg_pkg::MAX_GRID);
        end
    end

    // point count, overflow flag, bounding box, cell counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_ci    <= '0;
            r_cj    <= '0;
            r_min_x <= '0;
            r_max_x <= '0;
            r_min_y <= '0;
            r_max_y <= '0;
        end else if (i_cmd.set_clear) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_ci    <= '0;
            r_cj    <= '0;
            r_min_x <= '0;
            r_max_x <= '0;
            r_min_y <= '0;
            r_max_y <= '0;
        end else begin
            if (i_cmd.load) begin
                if (!r_count[CNT_W-1]) begin
                    r_count <= r_count + CNT_W'(1);
                    if (r_count == '0) begin
                        r_min_x <= i_x_coord;
                        r_max_x <= i_x_coord;
                        r_min_y <= i_y_coord;
                        r_max_y <= i_y_coord;
                    end else begin
                        if (i_x_coord < r_min_x) r_min_x <= i_x_coord;
                        if (i_x_coord > r_max_x) r_max_x <= i_x_coord;
                        if (i_y_coord < r_min_y) r_min_y <= i_y_coord;
                        if (i_y_coord > r_max_y) r_max_y <= i_y_coord;
                    end
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.cell_next) begin
                if (w_col_end) begin
                    r_ci <= '0;
                    r_cj <= r_cj + IDX_W'(1);
                end else begin
                    r_ci <= r_ci + IDX_W'(1);
                end
            end
        end
    end

    // point store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !r_count[CNT_W-1]) begin
            mem[r_count[PTR_W-1:0]] <= '{x: i_x_coord, y: i_y_coord, val: i_sample_value};
        end
        if (i_cmd.issue) begin
            r_rd <= mem[r_k];
        end
    end

    // spans, pitch, kernel width
    assign w_xspan_full = {r_max_x[COORD_W-1], r_max_x} - {r_min_x[COORD_W-1], r_min_x};
    assign w_yspan_full = {r_max_y[COORD_W-1], r_max_y} - {r_min_y[COORD_W-1], r_min_y};
    assign w_xspan      = w_xspan_full[COORD_W-1:0];
    assign w_yspan      = w_yspan_full[COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.h2_mul) begin
            r_h2_prod <= w_xspan * w_yspan;
        end
        if (i_cmd.pitch_latch) begin
            r_pitch <= w_quotient[COORD_W-1:0];
        end
        if (i_cmd.h2_latch) begin
            r_h2 <= (w_quotient[H2_W-1:0] == '0) ? H2_W'(1) : w_quotient[H2_W-1:0];
        end
    end

    // cell centre in half-lsb units
    assign w_off_x = {r_ci, 1'b1} * r_pitch;
    assign w_off_y = {r_cj, 1'b1} * r_pitch;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_setup) begin
            r_cx2 <= {{(CENTER_W-COORD_W-1){r_min_x[COORD_W-1]}}, r_min_x, 1'b0}
                     + {{(CENTER_W-OFF_W){1'b0}}, w_off_x};
            r_cy2 <= {{(CENTER_W-COORD_W-1){r_min_y[COORD_W-1]}}, r_min_y, 1'b0}
                     + {{(CENTER_W-OFF_W){1'b0}}, w_off_y};
        end
    end

    assign w_col_end = ({1'b0, r_ci} + GRID_W'(1)) == w_cols;
    assign w_row_end = ({1'b0, r_cj} + GRID_W'(1)) == w_rows;

    // point read pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_setup) begin
            r_k <= '0;
        end else if (i_cmd.issue) begin
            r_k <= r_k + PTR_W'(1);
        end
    end

    // distance to centre
    assign w_dx = {{(CENTER_W-COORD_W-1){r_rd.x[COORD_W-1]}}, r_rd.x, 1'b0} - r_cx2;
    assign w_dy = {{(CENTER_W-COORD_W-1){r_rd.y[COORD_W-1]}}, r_rd.y, 1'b0} - r_cy2;

    always_ff @(posedge i_clk) begin
        r_adx  <= w_dx[CENTER_W-1] ? ABS_W'(-w_dx) : w_dx[ABS_W-1:0];
        r_ady  <= w_dy[CENTER_W-1] ? ABS_W'(-w_dy) : w_dy[ABS_W-1:0];
        r_val1 <= r_rd.val;
        r_sqx  <= r_adx * r_adx;
        r_sqy  <= r_ady * r_ady;
        r_val2 <= r_val1;
    end

    // table index is floor(2*d2/h2); beyond the table the weight is zero
    assign w_d2  = D2_W'(r_sqx) + D2_W'(r_sqy);
    assign w_num = {w_d2, 1'b0};
    assign w_far = w_num >= NUM_W'({r_h2, {QB{1'b0}}});

    always_ff @(posedge i_clk) begin
        r_drem[0] <= w_num[REM_W-1:0];
        r_dq[0]   <= '0;
        r_dval[0] <= r_val2;
        r_dfar[0] <= w_far;
    end

    // one quotient bit per stage
    for (genvar s = 0; s < QB; s++) begin : g_idx_div
        localparam int B = QB - 1 - s;
        logic [REM_W-1:0] w_sub;
        logic             w_ge;
        assign w_sub = REM_W'(r_h2) << B;
        assign w_ge  = r_drem[s] >= w_sub;
        always_ff @(posedge i_clk) begin
            r_drem[s+1] <= w_ge ? (r_drem[s] - w_sub) : r_drem[s];
            r_dq[s+1]   <= {r_dq[s][QB-2:0], w_ge};
            r_dval[s+1] <= r_dval[s];
            r_dfar[s+1] <= r_dfar[s];
        end
    end

    // weight lookup and product
    assign w_w = r_dfar[QB] ? '0 : gkg_pkg::EXP_ROM[r_dq[QB]];

    always_ff @(posedge i_clk) begin
        r_w  <= w_w;
        r_wv <= $signed({1'b0, w_w}) * r_dval[QB];
    end

    // valid flags along the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ve <= 1'b0;
            for (int s = 0; s <= QB; s++) begin
                r_dv[s] <= 1'b0;
            end
        end else begin
            r_v0    <= i_cmd.issue;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_dv[0] <= r_v2;
            for (int s = 0; s < QB; s++) begin
                r_dv[s+1] <= r_dv[s];
            end
            r_ve <= r_dv[QB];
        end
    end

    always_comb begin
        w_div_busy_any = r_v0 | r_v1 | r_v2 | r_ve;
        for (int s = 0; s <= QB; s++) begin
            w_div_busy_any = w_div_busy_any | r_dv[s];
        end
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_setup) begin
            r_wt  <= '0;
            r_wvt <= '0;
        end else if (r_ve) begin
            r_wt  <= r_wt + WT_W'(r_w);
            r_wvt <= r_wvt + {{(WVT_W-PROD_W){r_wv[PROD_W-1]}}, r_wv};
        end
    end

    // shared divider operands
    assign w_neg       = r_wvt[WVT_W-1];
    assign w_mag       = w_neg ? WVT_W'(-r_wvt) : WVT_W'(r_wvt);
    assign w_div_start = i_cmd.pitch_go | i_cmd.h2_go | i_cmd.cell_go;

    always_comb begin
        if (i_cmd.pitch_go) begin
            w_dividend = DIV_N_W'(w_xspan);
            w_divisor  = DIV_D_W'(w_cols);
        end else if (i_cmd.h2_go) begin
            w_dividend = DIV_N_W'(r_h2_prod);
            w_divisor  = DIV_D_W'(r_count);
        end else begin
            w_dividend = DIV_N_W'(w_mag);
            w_divisor  = DIV_D_W'(r_wt);
        end
    end

    gkg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // result register
    assign w_wt_zero = (r_wt == '0);
    assign w_q_lo    = w_quotient[VALUE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_cell_value     <= w_wt_zero ? '0 : (w_neg ? -w_q_lo : w_q_lo);
            o_column_index   <= r_ci;
            o_row_index      <= r_cj;
            o_no_weight      <= w_wt_zero;
            o_points_dropped <= r_ovf;
            o_last_cell      <= w_col_end & w_row_end;
        end
    end

    // status to the controller
    assign o_sts.div_done   = w_div_done;
    assign o_sts.issue_last = (CNT_W'({1'b0, r_k}) + CNT_W'(1)) == r_count;
    assign o_sts.pipe_empty = ~w_div_busy_any;
    assign o_sts.grid_last  = w_col_end & w_row_end;

endmodule

@@ hdl/gkg_ctrl.sv @@
module gkg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_last_point,
    input  logic            i_ready,
    input  gkg_pkg::t_sts   i_sts,
    output logic            o_ready,
    output logic            o_valid,
    output gkg_pkg::t_cmd   o_cmd
);

    gkg_pkg::t_state r_state;
    gkg_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gkg_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gkg_pkg::ST_LOAD: begin
                if (i_valid && i_last_point) n_state = gkg_pkg::ST_PITCH_GO;
            end
            gkg_pkg::ST_PITCH_GO:   n_state = gkg_pkg::ST_PITCH_WAIT;
            gkg_pkg::ST_PITCH_WAIT: begin
                if (i_sts.div_done) n_state = gkg_pkg::ST_H2_MUL;
            end
            gkg_pkg::ST_H2_MUL:     n_state = gkg_pkg::ST_H2_GO;
            gkg_pkg::ST_H2_GO:      n_state = gkg_pkg::ST_H2_WAIT;
            gkg_pkg::ST_H2_WAIT: begin
                if (i_sts.div_done) n_state = gkg_pkg::ST_CELL_SETUP;
            end
            gkg_pkg::ST_CELL_SETUP: n_state = gkg_pkg::ST_CELL_ISSUE;
            gkg_pkg::ST_CELL_ISSUE: begin
                if (i_sts.issue_last) n_state = gkg_pkg::ST_CELL_DRAIN;
            end
            gkg_pkg::ST_CELL_DRAIN: begin
                if (i_sts.pipe_empty) n_state = gkg_pkg::ST_DIV_GO;
            end
            gkg_pkg::ST_DIV_GO:     n_state = gkg_pkg::ST_DIV_WAIT;
            gkg_pkg::ST_DIV_WAIT: begin
                if (i_sts.div_done) n_state = gkg_pkg::ST_OUT;
            end
            gkg_pkg::ST_OUT: begin
                if (i_ready) begin
                    n_state = i_sts.grid_last ? gkg_pkg::ST_LOAD : gkg_pkg::ST_CELL_SETUP;
                end
            end
            default: n_state = gkg_pkg::ST_LOAD;
        endcase
    end

    // commands and handshake
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            gkg_pkg::ST_LOAD: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            gkg_pkg::ST_PITCH_GO:   o_cmd.pitch_go = 1'b1;
            gkg_pkg::ST_PITCH_WAIT: o_cmd.pitch_latch = i_sts.div_done;
            gkg_pkg::ST_H2_MUL:     o_cmd.h2_mul = 1'b1;
            gkg_pkg::ST_H2_GO:      o_cmd.h2_go = 1'b1;
            gkg_pkg::ST_H2_WAIT:    o_cmd.h2_latch = i_sts.div_done;
            gkg_pkg::ST_CELL_SETUP: o_cmd.cell_setup = 1'b1;
            gkg_pkg::ST_CELL_ISSUE: o_cmd.issue = 1'b1;
            gkg_pkg::ST_CELL_DRAIN: ;
            gkg_pkg::ST_DIV_GO:     o_cmd.cell_go = 1'b1;
            gkg_pkg::ST_DIV_WAIT:   o_cmd.out_load = i_sts.div_done;
            gkg_pkg::ST_OUT: begin
                o_valid         = 1'b1;
                o_cmd.cell_next = i_ready & ~i_sts.grid_last;
                o_cmd.set_clear = i_ready & i_sts.grid_last;
            end
            default: ;
        endcase
    end

endmodule

@@ hdl/gaussian_kernel_gridder.sv @@
// channel   direction  handshake            payload
// point     in         i_valid / o_ready    i_x_coord, i_y_coord, i_sample_value, i_last_point
// cell      out        o_valid / i_ready    o_cell_value, o_column_index, o_row_index,
//                                           o_no_weight, o_points_dropped, o_last_cell
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// points without the last mark are taken one per cycle while the block is loading
// the last point starts the grid: the pitch and then the kernel width are computed
// on the shared one-bit-per-cycle divider, then each cell runs setup and the kernel
// pipeline (P points, one per cycle) and then the mean division and the output
// points are not taken while the grid runs; a stalled cell holds the grid at that cell
// reset is synchronous and active low; the point store needs no clearing
module gaussian_kernel_gridder (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [gkg_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [gkg_pkg::GRID_W-1:0]              i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [gkg_pkg::COORD_W-1:0]      i_x_coord,
    input  logic signed [gkg_pkg::COORD_W-1:0]      i_y_coord,
    input  logic signed [gkg_pkg::VALUE_W-1:0]      i_sample_value,
    input  logic                                    i_last_point,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [gkg_pkg::VALUE_W-1:0]      o_cell_value,
    output logic [gkg_pkg::IDX_W-1:0]               o_column_index,
    output logic [gkg_pkg::IDX_W-1:0]               o_row_index,
    output logic                                    o_no_weight,
    output logic                                    o_points_dropped,
    output logic                                    o_last_cell
);

    gkg_pkg::t_cmd w_cmd;
    gkg_pkg::t_sts w_sts;

    // sequencer
    gkg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_last_point (i_last_point),
        .i_ready      (i_ready),
        .i_sts        (w_sts),
        .o_ready      (o_ready),
        .o_valid      (o_valid),
        .o_cmd        (w_cmd)
    );

    // store, kernel pipeline and divider
    gkg_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_x_coord        (i_x_coord),
        .i_y_coord        (i_y_coord),
        .i_sample_value   (i_sample_value),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_cell_value     (o_cell_value),
        .o_column_index   (o_column_index),
        .o_row_index      (o_row_index),
        .o_no_weight      (o_no_weight),
        .o_points_dropped (o_points_dropped),
        .o_last_cell      (o_last_cell)
    );

endmodule

@@ bench/gkg_checker.sv @@
`timescale 1ns / 1ps

module gkg_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gkg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gkg_pkg::GRID_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    input  logic                                i_ready_in,
    input  logic signed [gkg_pkg::COORD_W-1:0]  i_x_coord,
    input  logic signed [gkg_pkg::COORD_W-1:0]  i_y_coord,
    input  logic signed [gkg_pkg::VALUE_W-1:0]  i_sample_value,
    input  logic                                i_last_point,
    input  logic                                i_valid_out,
    input  logic                                i_ready,
    input  logic signed [gkg_pkg::VALUE_W-1:0]  i_cell_value,
    input  logic [gkg_pkg::IDX_W-1:0]           i_column_index,
    input  logic [gkg_pkg::IDX_W-1:0]           i_row_index,
    input  logic                                i_no_weight,
    input  logic                                i_points_dropped,
    input  logic                                i_last_cell,
    output int                                  o_fail_count,
    output int                                  o_cells_pending
);

    localparam int VALUE_W    = gkg_pkg::VALUE_W;
    localparam int IDX_W      = gkg_pkg::IDX_W;
    localparam int WGT_W      = gkg_pkg::WGT_W;
    localparam int EXP_DEPTH  = gkg_pkg::EXP_DEPTH;
    localparam int COORD_W    = gkg_pkg::COORD_W;
    localparam int MAX_POINTS = gkg_pkg::MAX_POINTS;
    localparam int GRID_W     = gkg_pkg::GRID_W;
    localparam int MAX_GRID   = gkg_pkg::MAX_GRID;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [IDX_W-1:0]   col;
        logic [IDX_W-1:0]   row;
        logic               no_weight;
        logic               dropped;
        logic               last;
    } t_cell;

    t_cell cell_q[$];

    logic [WGT_W-1:0]          gauss_rom [0:EXP_DEPTH-1];
    logic signed [COORD_W-1:0] pt_x [0:MAX_POINTS-1];
    logic signed [COORD_W-1:0] pt_y [0:MAX_POINTS-1];
    logic signed [VALUE_W-1:0] pt_val [0:MAX_POINTS-1];
    int                        n_pts;
    longint                    min_x, max_x, min_y, max_y;
    bit                        dropped_seen;
    logic [GRID_W-1:0]         cfg_cols, cfg_rows;

    assign o_cells_pending = cell_q.size();

    // gaussian table: q30 ratio from a taylor series, repeated products
    initial begin
        longint term, ratio, v, w;
        term  = longint'(1) <<< 30;
        ratio = term;
        v     = term;
        for (int n = 1; n <= 12; n++) begin
            term = term * 16 / (longint'(EXP_DEPTH) * n);
            ratio = (n % 2 == 1) ? ratio - term : ratio + term;
        end
        for (int k = 0; k < EXP_DEPTH; k++) begin
            if (k > 0) begin
                v = (v * ratio + (longint'(1) <<< 29)) >>> 30;
            end
            w = (v + (longint'(1) <<< 13)) >>> 14;
            gauss_rom[k] = (w > 65535) ? 16'hFFFF : w[15:0];
        end
    end

    function automatic int grid_clamp(logic [GRID_W-1:0] n);
        if (n == 0) return 1;
        return (n > MAX_GRID) ? MAX_GRID : int'(n);
    endfunction

    // weighted mean of every stored point at each cell centre
    task automatic predict_grid();
        int     cols, rows;
        longint pitch, h2, cx2, cy2, dx, dy, d2, idx, w, wsum, vsum, q;
        t_cell  c;
        cols  = grid_clamp(cfg_cols);
        rows  = grid_clamp(cfg_rows);
        pitch = (max_x - min_x) / cols;
        h2    = (max_x - min_x) * (max_y - min_y) / n_pts;
        if (h2 == 0) h2 = 1;
        for (int j = 0; j < rows; j++) begin
            cy2 = 2 * min_y + (2 * j + 1) * pitch;
            for (int i = 0; i < cols; i++) begin
                cx2  = 2 * min_x + (2 * i + 1) * pitch;
                wsum = 0;
                vsum = 0;
                for (int k = 0; k < n_pts; k++) begin
                    dx  = 2 * longint'(pt_x[k]) - cx2;
                    dy  = 2 * longint'(pt_y[k]) - cy2;
                    d2  = dx * dx + dy * dy;
                    idx = d2 * EXP_DEPTH / (128 * h2);
                    w   = (idx < EXP_DEPTH) ? longint'(gauss_rom[idx]) : 0;
                    wsum += w;
                    vsum += w * longint'(pt_val[k]);
                end
                if (wsum == 0) begin
                    c.value     = '0;
                    c.no_weight = 1'b1;
                end else begin
                    q           = vsum / wsum;
                    c.value     = q[VALUE_W-1:0];
                    c.no_weight = 1'b0;
                end
                c.col     = i[IDX_W-1:0];
                c.row     = j[IDX_W-1:0];
                c.dropped = dropped_seen;
                c.last    = (i == cols - 1) && (j == rows - 1);
                cell_q    = {cell_q, c};
            end
        end
        n_pts        = 0;
        dropped_seen = 0;
    endtask

    task automatic report(string name, longint exp_v, longint act_v);
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_cell e;
        if (!i_rst_n) begin
            n_pts        = 0;
            dropped_seen = 0;
            cfg_cols     = GRID_W'(MAX_GRID);
            cfg_rows     = GRID_W'(MAX_GRID);
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == gkg_pkg::CFG_COLUMNS) cfg_cols = i_cfg_data;
                else if (i_cfg_index == gkg_pkg::CFG_ROWS) cfg_rows = i_cfg_data;
            end
            // point item accepted
            if (i_valid && i_ready_in) begin
                if (n_pts < MAX_POINTS) begin
                    if (n_pts == 0) begin
                        min_x = i_x_coord; max_x = i_x_coord;
                        min_y = i_y_coord; max_y = i_y_coord;
                    end else begin
                        if (i_x_coord < min_x) min_x = i_x_coord;
                        if (i_x_coord > max_x) max_x = i_x_coord;
                        if (i_y_coord < min_y) min_y = i_y_coord;
                        if (i_y_coord > max_y) max_y = i_y_coord;
                    end
                    pt_x[n_pts]   = i_x_coord;
                    pt_y[n_pts]   = i_y_coord;
                    pt_val[n_pts] = i_sample_value;
                    n_pts++;
                end else begin
                    dropped_seen = 1;
                end
                if (i_last_point) predict_grid();
            end
            // cell item accepted
            if (i_valid_out && i_ready) begin
                if (cell_q.size() == 0) begin
                    $display("%0t: unexpected cell item, actual value %0h", $time,
                             i_cell_value);
                    o_fail_count++;
                end else begin
                    e = cell_q.pop_front();
                    if (i_cell_value !== e.value) report("cell_value", e.value, i_cell_value);
                    if (i_column_index !== e.col) report("column_index", e.col, i_column_index);
                    if (i_row_index !== e.row) report("row_index", e.row, i_row_index);
                    if (i_no_weight !== e.no_weight)
                        report("no_weight", e.no_weight, i_no_weight);
                    if (i_points_dropped !== e.dropped)
                        report("points_dropped", e.dropped, i_points_dropped);
                    if (i_last_cell !== e.last) report("last_cell", e.last, i_last_cell);
                end
            end
        end
    end

    initial o_fail_count = 0;

endmodule

@@ bench/tb_gaussian_kernel_gridder.sv @@
`timescale 1ns / 1ps

module tb_gaussian_kernel_gridder;

    localparam int CFG_IDX_W   = gkg_pkg::CFG_IDX_W;
    localparam int GRID_W      = gkg_pkg::GRID_W;
    localparam int COORD_W     = gkg_pkg::COORD_W;
    localparam int VALUE_W     = gkg_pkg::VALUE_W;
    localparam int IDX_W       = gkg_pkg::IDX_W;
    localparam int CYCLE_LIMIT = 4000000;

    logic                       i_clk = 0;
    logic                       i_rst_n = 0;
    logic                       cfg_we = 0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [GRID_W-1:0]          cfg_data = '0;
    logic                       pt_valid = 0;
    logic                       pt_ready;
    logic signed [COORD_W-1:0]  x_coord = '0;
    logic signed [COORD_W-1:0]  y_coord = '0;
    logic signed [VALUE_W-1:0]  sample_value = '0;
    logic                       last_point = 0;
    logic                       cell_valid;
    logic                       cell_ready = 0;
    logic signed [VALUE_W-1:0]  cell_value;
    logic [IDX_W-1:0]           column_index, row_index;
    logic                       no_weight, points_dropped, last_cell;
    int                         fail_count, cells_pending;

    int  send_idle = 17;
    int  recv_idle = 61;
    int  points_sent = 0;
    bit  hold_req = 0;
    bit  hold_taken = 0;
    int  hold_left = 0;
    int  cycles = 0;

    gaussian_kernel_gridder i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(pt_valid), .o_ready(pt_ready),
        .i_x_coord(x_coord), .i_y_coord(y_coord),
        .i_sample_value(sample_value), .i_last_point(last_point),
        .o_valid(cell_valid), .i_ready(cell_ready),
        .o_cell_value(cell_value), .o_column_index(column_index),
        .o_row_index(row_index), .o_no_weight(no_weight),
        .o_points_dropped(points_dropped), .o_last_cell(last_cell)
    );

    gkg_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(pt_valid), .i_ready_in(pt_ready),
        .i_x_coord(x_coord), .i_y_coord(y_coord),
        .i_sample_value(sample_value), .i_last_point(last_point),
        .i_valid_out(cell_valid), .i_ready(cell_ready),
        .i_cell_value(cell_value), .i_column_index(column_index),
        .i_row_index(row_index), .i_no_weight(no_weight),
        .i_points_dropped(points_dropped), .i_last_cell(last_cell),
        .o_fail_count(fail_count), .o_cells_pending(cells_pending)
    );

    always #4 i_clk = ~i_clk;

    // cell receiver with random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cell_ready <= 0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1;
            hold_left  <= 600;
            cell_ready <= 0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            cell_ready <= 0;
        end else begin
            cell_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // one point item; called right at a rising edge
    task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              logic signed [VALUE_W-1:0] v, logic last);
        if ($urandom_range(99) < send_idle) begin
            pt_valid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        pt_valid     <= 1;
        x_coord      <= x;
        y_coord      <= y;
        sample_value <= v;
        last_point   <= last;
        do @(posedge i_clk); while (!pt_ready);
        points_sent++;
        if (points_sent == 130) begin
            send_idle = 61;
            recv_idle = 17;
        end else if (points_sent == 260) begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    // wait until every cell has come back, then let the block settle
    task automatic drain();
        pt_valid <= 0;
        do @(posedge i_clk); while (cells_pending != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_grid(logic [GRID_W-1:0] cols, logic [GRID_W-1:0] rows);
        cfg_we    <= 1;
        cfg_index <= gkg_pkg::CFG_COLUMNS;
        cfg_data  <= cols;
        @(posedge i_clk);
        cfg_index <= gkg_pkg::CFG_ROWS;
        cfg_data  <= rows;
        @(posedge i_clk);
        cfg_we    <= 0;
    endtask

    // random point set: clustered, scattered or on one vertical line
    task automatic send_set(int n);
        int                        mode;
        logic signed [COORD_W-1:0] bx, by, x, y;
        logic signed [VALUE_W-1:0] v;
        mode = $urandom_range(9);
        bx   = COORD_W'($urandom);
        by   = COORD_W'($urandom);
        for (int k = 0; k < n; k++) begin
            if (mode < 6) begin
                x = bx + $signed(16'($urandom_range(1200))) - 16'sd600;
                y = by + $signed(16'($urandom_range(1200))) - 16'sd600;
            end else if (mode < 8) begin
                x = COORD_W'($urandom);
                y = COORD_W'($urandom);
            end else begin
                x = bx;
                y = COORD_W'($urandom);
            end
            v = VALUE_W'($urandom);
            if ($urandom_range(9) == 0) v = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            send_point(x, y, v, k == n - 1);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: a lone point at the corner extremes, reset grid size
        send_point(-16'sd32768, 16'sd32767, -24'sd8388608, 1);
        drain();
        set_grid(4'd1, 4'd8);
        send_point(-16'sd32768, -16'sd32768, 24'sh7FFFFF, 0);
        send_point(16'sd32767, 16'sd32767, 24'sh800000, 1);
        drain();
        // columns and rows out of range clamp
        set_grid(4'd0, 4'd15);
        send_point(16'sd100, 16'sd5, 24'sd1000, 0);
        send_point(16'sd300, -16'sd9, -24'sd77, 0);
        send_point(16'sd200, 16'sd40, 24'sd5, 1);
        drain();
        // zero x span puts every centre on the corner
        set_grid(4'd8, 4'd2);
        send_point(16'sd1234, -16'sd400, 24'sd9, 0);
        send_point(16'sd1234, 16'sd400, -24'sd900, 0);
        send_point(16'sd1234, 16'sd0, 24'sd33, 1);
        drain();
        // points far apart give zero weights
        set_grid(4'd3, 4'd3);
        send_point(-16'sd32768, 16'sd0, 24'sd1, 0);
        send_point(16'sd32767, 16'sd0, 24'sd2, 0);
        send_point(16'sd0, 16'sd1, 24'sd3, 0);
        send_point(16'sd0, -16'sd1, 24'sd4, 1);
        drain();

        // random sets; the receiver holds off once while points keep coming
        while (points_sent < 355) begin
            set_grid(GRID_W'($urandom_range(15)), GRID_W'($urandom_range(15)));
            send_set($urandom_range(1, 12));
            if (points_sent > 60 && !hold_req) begin
                hold_req <= 1;
                send_set($urandom_range(2, 6));
                send_set($urandom_range(2, 6));
            end
            drain();
        end

        // a last full-size grid
        set_grid(4'd8, 4'd8);
        send_set(5);
        drain();
        repeat (100) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/gkg_pkg.sv
hdl/gkg_div.sv
hdl/gkg_dpath.sv
hdl/gkg_ctrl.sv
hdl/gaussian_kernel_gridder.sv
bench/gkg_checker.sv
bench/tb_gaussian_kernel_gridder.sv
